### rtl/dtt_pkg.sv
// Shared types, codes and helpers for the deadline timer table.
package dtt_pkg;

  localparam int SLOTS_DEF = 16;

  localparam logic [1:0] FN_TICK    = 2'd0;
  localparam logic [1:0] FN_SET     = 2'd1;
  localparam logic [1:0] FN_KILL    = 2'd2;
  localparam logic [1:0] FN_KILLALL = 2'd3;

  localparam logic [2:0] EV_FIRED   = 3'd0;
  localparam logic [2:0] EV_SET     = 3'd1;
  localparam logic [2:0] EV_KILL    = 3'd2;
  localparam logic [2:0] EV_KILLALL = 3'd3;
  localparam logic [2:0] EV_WAIT    = 3'd4;

  localparam logic [30:0] WAIT_MAX = 31'h7FFF_FFFF;

  typedef logic [3:0][31:0] tags_t;

  typedef struct packed {
    logic        periodic;
    logic        by_callback;
    logic [7:0]  owner;
    logic [30:0] period;
    logic [31:0] due;
  } rec_t;

  typedef struct packed {
    logic        fire;
    logic        shorter;
    logic        owner_hit;
    logic [31:0] cand;
    logic [31:0] due_new;
  } unit_res_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [7:0]  owner;
    logic        via_call;
    tags_t       tags;
    logic        ok;
    logic [30:0] wait_ms;
    logic        last;
  } row_t;

  function automatic row_t mk_row(input logic [2:0] kind, input logic [3:0] slot,
                                  input logic ok_bit, input logic last_bit);
    row_t r;
    r = '0;
    r.kind = kind;
    r.slot = slot;
    r.ok   = ok_bit;
    r.last = last_bit;
    return r;
  endfunction

endpackage

### rtl/dtt_store.sv
// Slot record and user tag memories, one write port and one registered read port.
module dtt_store import dtt_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     tag_we,
  input  logic [$clog2(SLOTS)-1:0] waddr,
  input  rec_t                     wrec,
  input  tags_t                    wtags,
  input  logic [$clog2(SLOTS)-1:0] raddr,
  output rec_t                     rrec,
  output tags_t                    rtags
);

  rec_t  rec_mem [SLOTS];
  tags_t tag_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      rec_mem[waddr] <= wrec;
    end
    if (tag_we) begin
      tag_mem[waddr] <= wtags;
    end
    rrec  <= rec_mem[raddr];
    rtags <= tag_mem[raddr];
  end

endmodule

### rtl/dtt_unit.sv
// Shared timer arithmetic: due sum, expiry compare, least-wait compare, owner match.
module dtt_unit import dtt_pkg::*; (
  input  logic [31:0] now,
  input  logic [31:0] due,
  input  logic [30:0] period_in,
  input  logic [30:0] wait_in,
  input  logic [7:0]  owner_ref,
  input  logic [7:0]  owner_rec,
  output unit_res_t   res
);

  logic [32:0] diff;
  logic [31:0] cand;
  logic        fire;

  assign diff = {1'b0, due} - {1'b0, now};
  assign fire = diff[32] || (diff[31:0] == 32'd0);
  assign cand = fire ? {1'b0, period_in} : diff[31:0];

  always_comb begin
    res           = '0;
    res.fire      = fire;
    res.cand      = cand;
    res.shorter   = cand < {1'b0, wait_in};
    res.due_new   = now + {1'b0, period_in};
    res.owner_hit = (owner_ref == 8'd0) || (owner_ref == owner_rec);
  end

endmodule

### rtl/deadline_timer_table.sv
// Deadline timer table: top level with the slot sequencer.
// An operation is taken when start is high and busy is low; results appear one per
// cycle with done high and cannot be held off. A tick or killall walks every slot
// through the record memory read port, one slot per cycle, then passes through the
// drain and finish states before it is ready again. A set scans the live bits from
// slot 0 and returns to idle once it takes a free slot or reaches the last slot; a
// kill returns to idle straight from the scan state. Fired events come in ascending
// slot order while the walk runs, and the next-wait result closes each tick.
module deadline_timer_table import dtt_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [31:0] now,
  input  logic [30:0] period,
  input  logic        repeat_req,
  input  logic [7:0]  owner,
  input  logic        direct_call,
  input  logic [31:0] tag_a,
  input  logic [31:0] tag_b,
  input  logic [31:0] tag_c,
  input  logic [31:0] tag_d,
  input  logic [3:0]  handle,
  output logic        done,
  output logic [2:0]  event_kind,
  output logic [3:0]  slot_out,
  output logic [7:0]  owner_out,
  output logic        via_call,
  output logic [31:0] tag_a_out,
  output logic [31:0] tag_b_out,
  output logic [31:0] tag_c_out,
  output logic [31:0] tag_d_out,
  output logic        ok,
  output logic [30:0] wait_ms,
  output logic        last
);

  localparam int IW = $clog2(SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  typedef enum logic [1:0] {IDLE, SCAN, DRAIN, FINISH} state_t;

  state_t      state;
  logic [SLOTS-1:0] live;
  logic [IW-1:0] idx;
  logic [IW-1:0] b_idx;
  logic        b_vld;
  logic [1:0]  func_r;
  logic [31:0] now_r;
  logic [30:0] period_r;
  logic        rep_r;
  logic [7:0]  own_r;
  logic        call_r;
  tags_t       tags_r;
  logic [3:0]  handle_r;
  logic [30:0] wait_r;
  row_t        res;

  rec_t        rd_rec;
  tags_t       rd_tags;
  rec_t        wr_rec;
  logic        wr_en;
  logic        tag_we;
  logic [IW-1:0] wr_idx;
  unit_res_t   ures;
  logic        set_hit;
  logic        b_live;
  logic        kill_hit;
  logic [IW-1:0] h_idx;

  assign h_idx    = IW'(handle_r);
  assign kill_hit = (32'(handle_r) < SLOTS) && live[h_idx];
  assign set_hit  = (state == SCAN) && (func_r == FN_SET) && !live[idx];
  assign b_live   = b_vld && live[b_idx];

  dtt_unit u_unit (
    .now       (now_r),
    .due       (rd_rec.due),
    .period_in (b_vld ? rd_rec.period : period_r),
    .wait_in   (wait_r),
    .owner_ref (own_r),
    .owner_rec (rd_rec.owner),
    .res       (ures)
  );

  always_comb begin
    wr_rec = rd_rec;
    wr_rec.due = ures.due_new;
    if (!b_vld) begin
      wr_rec.periodic    = rep_r;
      wr_rec.by_callback = call_r;
      wr_rec.owner       = own_r;
      wr_rec.period      = period_r;
    end
  end

  assign wr_en  = set_hit ||
                  (b_live && (func_r == FN_TICK) && ures.fire && rd_rec.periodic);
  assign tag_we = set_hit;
  assign wr_idx = b_vld ? b_idx : idx;

  dtt_store #(.SLOTS(SLOTS)) u_store (
    .clk    (clk),
    .we     (wr_en),
    .tag_we (tag_we),
    .waddr  (wr_idx),
    .wrec   (wr_rec),
    .wtags  (tags_r),
    .raddr  (idx),
    .rrec   (rd_rec),
    .rtags  (rd_tags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      live  <= '0;
      b_vld <= 1'b0;
      done  <= 1'b0;
    end else begin
      done  <= 1'b0;
      b_vld <= 1'b0;
      case (state)
        IDLE: begin
          if (start) begin
            func_r   <= func;
            now_r    <= now;
            period_r <= (period == 31'd0) ? 31'd1 : period;
            rep_r    <= repeat_req;
            own_r    <= owner;
            call_r   <= direct_call;
            tags_r   <= {tag_d, tag_c, tag_b, tag_a};
            handle_r <= handle;
            wait_r   <= WAIT_MAX;
            idx      <= '0;
            state    <= SCAN;
          end
        end
        SCAN: begin
          case (func_r)
            FN_SET: begin
              if (!live[idx]) begin
                live[idx] <= 1'b1;
                res   <= mk_row(EV_SET, 4'(idx), 1'b1, 1'b1);
                done  <= 1'b1;
                state <= IDLE;
              end else if (idx == LAST_IDX) begin
                res   <= mk_row(EV_SET, 4'd0, 1'b0, 1'b1);
                done  <= 1'b1;
                state <= IDLE;
              end else begin
                idx <= idx + 1'b1;
              end
            end
            FN_KILL: begin
              if (kill_hit) begin
                live[h_idx] <= 1'b0;
              end
              res   <= mk_row(EV_KILL, 4'd0, kill_hit, 1'b1);
              done  <= 1'b1;
              state <= IDLE;
            end
            default: begin
              b_vld <= 1'b1;
              b_idx <= idx;
              if (idx == LAST_IDX) begin
                state <= DRAIN;
              end else begin
                idx <= idx + 1'b1;
              end
            end
          endcase
        end
        DRAIN: begin
          state <= FINISH;
        end
        FINISH: begin
          if (func_r == FN_TICK) begin
            res         <= mk_row(EV_WAIT, 4'd0, 1'b1, 1'b1);
            res.wait_ms <= wait_r;
          end else begin
            res <= mk_row(EV_KILLALL, 4'd0, 1'b1, 1'b1);
          end
          done  <= 1'b1;
          state <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase

      // slot evaluation, in the cycle after the read
      if (b_live) begin
        if (func_r == FN_TICK) begin
          if (ures.fire) begin
            res          <= mk_row(EV_FIRED, 4'(b_idx), 1'b1, 1'b0);
            res.owner    <= rd_rec.owner;
            res.via_call <= rd_rec.by_callback;
            res.tags     <= rd_tags;
            done         <= 1'b1;
            if (!rd_rec.periodic) begin
              live[b_idx] <= 1'b0;
            end
          end
          if ((!ures.fire || rd_rec.periodic) && ures.shorter) begin
            wait_r <= ures.cand[30:0];
          end
        end else if (ures.owner_hit) begin
          live[b_idx] <= 1'b0;
        end
      end
    end
  end

  assign busy       = (state != IDLE);
  assign event_kind = res.kind;
  assign slot_out   = res.slot;
  assign owner_out  = res.owner;
  assign via_call   = res.via_call;
  assign tag_a_out  = res.tags[0];
  assign tag_b_out  = res.tags[1];
  assign tag_c_out  = res.tags[2];
  assign tag_d_out  = res.tags[3];
  assign ok         = res.ok;
  assign wait_ms    = res.wait_ms;
  assign last       = res.last;

  a_fired_not_last: assert property (@(posedge clk) disable iff (rst)
    done && (event_kind == EV_FIRED) |-> !last)
    else $error("fired event marked last");

  a_last_ends_op: assert property (@(posedge clk) disable iff (rst)
    done && last |-> !busy)
    else $error("final result while operation still running");

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    done && !last |-> busy)
    else $error("non-final result after operation ended");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("transfer did not start an operation");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    b_vld |-> (func_r == FN_TICK || func_r == FN_KILLALL) && !set_hit)
    else $error("slot walk overlaps a set");

endmodule
